// ===== design/grid_motion_collision_filter_core_defines.svh =====
// Assertion macros shared by the collision filter RTL.
// No dependencies; included by the modules that carry checks.
`ifndef GRID_MOTION_COLLISION_FILTER_CORE_DEFINES_SVH
`define GRID_MOTION_COLLISION_FILTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GMCF_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
`define GMCF_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define GMCF_ASSERT_IMP(label, clk, rst_n, pre, post)
`define GMCF_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== design/gmcf_pkg.sv =====
// Types and constants of the collision filter.
// No dependencies.
package gmcf_pkg;

	localparam int PXW     = 13;
	localparam int OUT_W   = 13;
	localparam int FACE_W  = 4;
	localparam int OUT_MAX = 4095;
	localparam int OUT_MIN = -4096;

	localparam logic [FACE_W-1:0] FACE_LEFT   = 4'b0001;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 4'b0010;
	localparam logic [FACE_W-1:0] FACE_TOP    = 4'b0100;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 4'b1000;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CFG_CLAMP,
		CFG_COLS,
		CFG_ROWS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_XSTART,
		T_XWAIT,
		T_YSTART,
		T_YWAIT,
		T_OUT
	} top_state_t;

	typedef enum logic {
		AX_IDLE,
		AX_SCAN
	} ax_state_t;

	typedef struct packed {
		logic [3:0]        pad;
		logic signed [7:0] move_dy;
		logic signed [7:0] move_dx;
		logic [7:0]        rect_height;
		logic [7:0]        rect_width;
		logic [11:0]       rect_y;
		logic [11:0]       rect_x;
		logic [3:0]        cell_faces;
		logic [7:0]        cell_col;
		logic [7:0]        cell_row;
	} in_word_t;

	typedef struct packed {
		logic [5:0]              pad;
		logic signed [OUT_W-1:0] allowed_dy;
		logic signed [OUT_W-1:0] allowed_dx;
	} out_word_t;

	typedef struct packed {
		logic              start;
		logic              forward;
		logic              rows_scan;
		logic [FACE_W-1:0] face;
		logic [PXW-1:0]    lead;
		logic signed [7:0] d;
		logic [PXW-1:0]    lo;
		logic [PXW-1:0]    hi;
	} axis_cmd_t;

	typedef struct packed {
		logic                    done;
		logic signed [OUT_W-1:0] res;
	} axis_rsp_t;

endpackage

// ===== design/gmcf_cell_store.sv =====
// Cell face store: one write port, one registered read port, clearing pass after reset.
// Depends on gmcf_pkg and the defines header.
`include "grid_motion_collision_filter_core_defines.svh"

module gmcf_cell_store import gmcf_pkg::*; #(
	parameter int AW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [FACE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [FACE_W-1:0] rd_data,
	output logic              busy
);

	logic [FACE_W-1:0] mem [2**AW];
	logic              clr_active_q;
	logic [AW-1:0]     clr_addr_q;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [FACE_W-1:0] mem_wdata;

	assign busy      = clr_active_q;
	assign mem_we    = clr_active_q || wr_en;
	assign mem_addr  = clr_active_q ? clr_addr_q : wr_addr;
	assign mem_wdata = clr_active_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	`GMCF_ASSERT_IMP(a_no_read_in_clear, clk, arst_n, clr_active_q, !rd_en)
	`GMCF_ASSERT_NXT(a_clear_ends, clk, arst_n, clr_active_q && (clr_addr_q == '1), !clr_active_q)

endmodule

// ===== design/gmcf_axis_unit.sv =====
// Shared axis filter: edge and boundary arithmetic, then a scan of one cell per cycle.
// Depends on gmcf_pkg and the defines header; reads the cell store.
`include "grid_motion_collision_filter_core_defines.svh"

module gmcf_axis_unit import gmcf_pkg::*; #(
	parameter int CELL_SHIFT = 3,
	parameter int ROW_W      = 8,
	parameter int COL_W      = 8,
	parameter int SZW        = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  axis_cmd_t              cmd,
	input  logic                   clamp,
	input  logic [SZW-1:0]         size_along,
	input  logic [SZW-1:0]         size_perp,
	output logic                   rd_en,
	output logic [ROW_W+COL_W-1:0] rd_addr,
	input  logic [FACE_W-1:0]      rd_data,
	output axis_rsp_t              rsp
);

	localparam int CW = PXW - CELL_SHIFT;
	localparam int SW = ((PXW > SZW + CELL_SHIFT) ? PXW : SZW + CELL_SHIFT) + 2;
	localparam logic signed [SW-1:0] RES_MAX = SW'(OUT_MAX);
	localparam logic signed [SW-1:0] RES_MIN = SW'(OUT_MIN);

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > RES_MAX) begin
			r = OUT_W'(RES_MAX);
		end else if (v < RES_MIN) begin
			r = OUT_W'(RES_MIN);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

	ax_state_t st_q, st_d;

	logic signed [SW-1:0] lead_s, d_s, nx_s, px_s, edge_s, direct_val, brk_val;
	logic [CW-1:0]        cell_lead, cell_nx;
	logic                 line_on_map, scan_go;

	logic                    done_q, pend_s1, stop_q, last_s1, onmap_s1;
	logic                    rows_scan_q;
	logic [FACE_W-1:0]       face_q;
	logic [CW-1:0]           i_q, hi_q, line_q;
	logic signed [OUT_W-1:0] res_q, brk_q, dres_q;
	logic                    onmap_i, hit, fin;

	// edge arithmetic on the start cycle
	always_comb begin
		lead_s      = SW'(cmd.lead);
		d_s         = SW'(cmd.d);
		nx_s        = lead_s + d_s;
		px_s        = SW'(size_along) << CELL_SHIFT;
		cell_lead   = CW'(cmd.lead >> CELL_SHIFT);
		cell_nx     = CW'(nx_s[PXW-1:0] >> CELL_SHIFT);
		line_on_map = int'(cell_nx) < int'(size_along);
		scan_go     = 1'b0;
		direct_val  = d_s;
		if (cmd.forward) begin
			edge_s  = SW'(cell_nx) << CELL_SHIFT;
			brk_val = edge_s - lead_s - 1;
			if (clamp && (nx_s >= px_s)) begin
				direct_val = px_s - 1 - lead_s;
			end else if ((cell_lead != cell_nx) && line_on_map) begin
				scan_go = 1'b1;
			end
		end else begin
			edge_s  = SW'(cell_lead) << CELL_SHIFT;
			brk_val = edge_s - lead_s;
			if (nx_s < 0) begin
				direct_val = -lead_s;
			end else if ((cell_lead != cell_nx) && line_on_map) begin
				scan_go = 1'b1;
			end
		end
	end

	assign onmap_i = int'(i_q) < int'(size_perp);
	assign hit     = pend_s1 && onmap_s1 && ((rd_data & face_q) != '0);
	assign fin     = pend_s1 && (hit || last_s1);
	assign rd_addr = rows_scan_q ? {ROW_W'(i_q), COL_W'(line_q)} : {ROW_W'(line_q), COL_W'(i_q)};
	assign rsp     = '{done: done_q, res: res_q};

	always_comb begin
		st_d  = st_q;
		rd_en = 1'b0;
		unique case (st_q)
			AX_IDLE: begin
				if (cmd.start && scan_go) begin
					st_d = AX_SCAN;
				end
			end
			AX_SCAN: begin
				rd_en = !stop_q && !fin && onmap_i;
				if (fin) begin
					st_d = AX_IDLE;
				end
			end
			default: st_d = AX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= AX_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			stop_q  <= 1'b0;
		end else begin
			done_q <= ((st_q == AX_IDLE) && cmd.start && !scan_go) || ((st_q == AX_SCAN) && fin);
			if (st_q == AX_IDLE) begin
				pend_s1 <= 1'b0;
				stop_q  <= 1'b0;
			end else if (!fin) begin
				pend_s1 <= !stop_q;
				if (!stop_q && (i_q == hi_q)) begin
					stop_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == AX_IDLE) && cmd.start) begin
			res_q       <= sat_out(direct_val);
			brk_q       <= sat_out(brk_val);
			dres_q      <= OUT_W'(cmd.d);
			line_q      <= cell_nx;
			i_q         <= CW'(cmd.lo >> CELL_SHIFT);
			hi_q        <= CW'(cmd.hi >> CELL_SHIFT);
			face_q      <= cmd.face;
			rows_scan_q <= cmd.rows_scan;
		end else if (st_q == AX_SCAN) begin
			if (fin) begin
				res_q <= hit ? brk_q : dres_q;
			end else if (!stop_q) begin
				i_q      <= i_q + 1'b1;
				last_s1  <= (i_q == hi_q);
				onmap_s1 <= onmap_i;
			end
		end
	end

	`GMCF_ASSERT_IMP(a_start_when_idle, clk, arst_n, cmd.start, (st_q == AX_IDLE) && !done_q)
	`GMCF_ASSERT_NXT(a_scan_ends, clk, arst_n, (st_q == AX_SCAN) && stop_q, st_q == AX_IDLE)

endmodule

// ===== design/grid_motion_collision_filter_core.sv =====
// Top level of the grid motion collision filter: ports, config registers, query sequencer.
// Depends on gmcf_pkg, gmcf_cell_store, gmcf_axis_unit and the defines header.
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata request word, s_tuser req_type
// m_      | out | m_tvalid/m_tready  | m_tdata allowed move
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A write word goes straight into the store. A query runs the X axis, then the Y axis,
// each with no cell check or with a scan of the cells spanned, one store read per cycle.
// After reset a clearing pass over all 2**(ROW_W+COL_W) store cells (65536 at defaults) holds
// s_tready low; config writes are taken throughout.
// A result held in m_tdata stalls only the next query, in its output state.
`include "grid_motion_collision_filter_core_defines.svh"

module grid_motion_collision_filter_core import gmcf_pkg::*; #(
	parameter int CELL_SHIFT  = 3,
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// row[7:0] col[15:8] faces[19:16] x[31:20] y[43:32] width[51:44] height[59:52]
	// dx[67:60] dy[75:68], zero pad above
	input  logic [79:0] s_tdata,
	// req_type[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// allowed_dx[12:0] allowed_dy[25:13], zero pad above
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int AW    = ROW_W + COL_W;
	localparam int SZC   = $clog2(MAX_COLUMNS + 1);
	localparam int SZR   = $clog2(MAX_ROWS + 1);
	localparam int SZW   = (SZC > SZR) ? SZC : SZR;

	top_state_t st_q, st_d;

	in_word_t  in_w;
	out_word_t out_q;
	logic      m_tvalid_q;

	logic       clamp_q;
	logic [8:0] cols_q, rows_q;
	logic [SZW-1:0] cols_eff, rows_eff, size_along, size_perp;

	logic [11:0]       x_q, y_q;
	logic [7:0]        w_q, h_q;
	logic signed [7:0] dx_q, dy_q;
	logic [PXW-1:0]    x2, y2;
	logic signed [OUT_W-1:0] resx_q, resy_q;

	logic      in_acc, wr_en, clr_busy, axis_y, ld_out;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic              rd_en;
	logic [FACE_W-1:0] rd_data;
	axis_cmd_t ax_cmd;
	axis_rsp_t ax_rsp;

	assign in_w      = s_tdata;
	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == T_IDLE) && !clr_busy;
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;

	assign cols_eff = (cols_q == '0) ? SZW'(1) :
		(int'(cols_q) > MAX_COLUMNS) ? SZW'(MAX_COLUMNS) : SZW'(cols_q);
	assign rows_eff = (rows_q == '0) ? SZW'(1) :
		(int'(rows_q) > MAX_ROWS) ? SZW'(MAX_ROWS) : SZW'(rows_q);

	assign wr_en   = in_acc && (s_tuser == REQ_WRITE) && (int'(in_w.cell_row) < MAX_ROWS)
		&& (int'(in_w.cell_col) < MAX_COLUMNS);
	assign wr_addr = {ROW_W'(in_w.cell_row), COL_W'(in_w.cell_col)};

	assign x2 = PXW'(x_q) + PXW'(w_q) - 1'b1;
	assign y2 = PXW'(y_q) + PXW'(h_q) - 1'b1;

	assign axis_y     = (st_q == T_YSTART) || (st_q == T_YWAIT);
	assign size_along = axis_y ? rows_eff : cols_eff;
	assign size_perp  = axis_y ? cols_eff : rows_eff;
	assign ld_out     = (st_q == T_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		ax_cmd.start     = (st_q == T_XSTART) || (st_q == T_YSTART);
		ax_cmd.rows_scan = !axis_y;
		if (axis_y) begin
			ax_cmd.forward = !dy_q[7] && (dy_q != '0);
			ax_cmd.face    = ax_cmd.forward ? FACE_TOP : FACE_BOTTOM;
			ax_cmd.lead    = ax_cmd.forward ? y2 : PXW'(y_q);
			ax_cmd.d       = dy_q;
			ax_cmd.lo      = PXW'(x_q);
			ax_cmd.hi      = x2;
		end else begin
			ax_cmd.forward = !dx_q[7] && (dx_q != '0);
			ax_cmd.face    = ax_cmd.forward ? FACE_LEFT : FACE_RIGHT;
			ax_cmd.lead    = ax_cmd.forward ? x2 : PXW'(x_q);
			ax_cmd.d       = dx_q;
			ax_cmd.lo      = PXW'(y_q);
			ax_cmd.hi      = y2;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			T_IDLE:   if (in_acc && (s_tuser == REQ_QUERY)) st_d = T_XSTART;
			T_XSTART: st_d = T_XWAIT;
			T_XWAIT:  if (ax_rsp.done) st_d = T_YSTART;
			T_YSTART: st_d = T_YWAIT;
			T_YWAIT:  if (ax_rsp.done) st_d = T_OUT;
			T_OUT:    if (ld_out) st_d = T_IDLE;
			default:  st_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b1;
			cols_q  <= 9'd256;
			rows_q  <= 9'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CLAMP: clamp_q <= cfg_data[0];
				CFG_COLS:  cols_q  <= cfg_data;
				CFG_ROWS:  rows_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ld_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == REQ_QUERY)) begin
			x_q  <= in_w.rect_x;
			y_q  <= in_w.rect_y;
			w_q  <= (in_w.rect_width == '0) ? 8'd1 : in_w.rect_width;
			h_q  <= (in_w.rect_height == '0) ? 8'd1 : in_w.rect_height;
			dx_q <= in_w.move_dx;
			dy_q <= in_w.move_dy;
		end
		if ((st_q == T_XWAIT) && ax_rsp.done) begin
			resx_q <= ax_rsp.res;
		end
		if ((st_q == T_YWAIT) && ax_rsp.done) begin
			resy_q <= ax_rsp.res;
		end
		if (ld_out) begin
			out_q.pad        <= '0;
			out_q.allowed_dx <= resx_q;
			out_q.allowed_dy <= resy_q;
		end
	end

	gmcf_cell_store #(
		.AW(AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_w.cell_faces),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (clr_busy)
	);

	gmcf_axis_unit #(
		.CELL_SHIFT (CELL_SHIFT),
		.ROW_W      (ROW_W),
		.COL_W      (COL_W),
		.SZW        (SZW)
	) u_axis (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ax_cmd),
		.clamp      (clamp_q),
		.size_along (size_along),
		.size_perp  (size_perp),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.rsp        (ax_rsp)
	);

	`GMCF_ASSERT_IMP(a_clear_idle, clk, arst_n, clr_busy, st_q == T_IDLE)
	`GMCF_ASSERT_IMP(a_done_in_wait, clk, arst_n, ax_rsp.done, (st_q == T_XWAIT) || (st_q == T_YWAIT))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for grid_motion_collision_filter_core: cell writes and motion
// queries over the stream ports, map settings over the config channel, in-bench move predictor.
// Depends on gmcf_pkg and the core RTL.
module tb_top import gmcf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL_SHIFT   = 3;
	localparam int MAX_COLUMNS  = 256;
	localparam int MAX_ROWS     = 256;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int IDLE_LIMIT   = 200000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data  = '0;

	// predictor state
	logic [3:0]  face_map [MAX_ROWS][MAX_COLUMNS];
	logic        clamp_q = 1'b1;
	logic [8:0]  cols_q  = 9'd256;
	logic [8:0]  rows_q  = 9'd256;
	out_word_t   move_q [$];

	int mismatches, results_checked, writes_seen, queries_seen, settings_used;
	int idle_cycles, burst_left;
	bit sender_steady, rx_hold_req;

	grid_motion_collision_filter_core #(
		.CELL_SHIFT(CELL_SHIFT),
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int eff(logic [8:0] v, int mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return int'(v);
	endfunction

	function automatic bit solid(int row, int col, logic [3:0] face);
		if (row < 0 || col < 0 || row >= eff(rows_q, MAX_ROWS) || col >= eff(cols_q, MAX_COLUMNS))
			return 1'b0;
		return |(face_map[row][col] & face);
	endfunction

	function automatic bit span_hit(int lo, int hi, int line, bit rows_scan, logic [3:0] face);
		for (int i = lo >> CELL_SHIFT; i <= (hi >> CELL_SHIFT); i++) begin
			if (rows_scan ? solid(i, line, face) : solid(line, i, face)) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int move_fwd(int lead, int d, int lo, int hi, int cells, bit rows_scan,
			logic [3:0] face);
		int nx, nc;
		nx = lead + d;
		if (clamp_q && nx >= (cells << CELL_SHIFT)) return (cells << CELL_SHIFT) - 1 - lead;
		nc = nx >> CELL_SHIFT;
		if ((lead >> CELL_SHIFT) != nc && span_hit(lo, hi, nc, rows_scan, face))
			return (nc << CELL_SHIFT) - (lead + 1);
		return d;
	endfunction

	function automatic int move_back(int lead, int d, int lo, int hi, bit rows_scan,
			logic [3:0] face);
		int nx;
		nx = lead + d;
		if (nx < 0) return -lead;
		if ((lead >> CELL_SHIFT) != (nx >> CELL_SHIFT) &&
				span_hit(lo, hi, nx >> CELL_SHIFT, rows_scan, face))
			return ((lead >> CELL_SHIFT) << CELL_SHIFT) - lead;
		return d;
	endfunction

	function automatic int sat13(int v);
		if (v < OUT_MIN) return OUT_MIN;
		if (v > OUT_MAX) return OUT_MAX;
		return v;
	endfunction

	// accepted words: config, store writes, query prediction, result check
	always @(posedge clk) begin : scoreboard
		in_word_t  w;
		out_word_t exp_w, got_w;
		int x, y, wd, ht, dx, dy, x2, y2;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_CLAMP: clamp_q = cfg_data[0];
					CFG_COLS:  cols_q  = cfg_data;
					CFG_ROWS:  rows_q  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				w = s_tdata;
				if (s_tuser == REQ_WRITE) begin
					face_map[w.cell_row][w.cell_col] = w.cell_faces;
					writes_seen++;
				end else begin
					x  = w.rect_x;
					y  = w.rect_y;
					wd = (w.rect_width == 0) ? 1 : w.rect_width;
					ht = (w.rect_height == 0) ? 1 : w.rect_height;
					dx = w.move_dx;
					dy = w.move_dy;
					x2 = x + wd - 1;
					y2 = y + ht - 1;
					if (dx > 0)
						dx = move_fwd(x2, dx, y, y2, eff(cols_q, MAX_COLUMNS), 1'b1, FACE_LEFT);
					else if (dx < 0)
						dx = move_back(x, dx, y, y2, 1'b1, FACE_RIGHT);
					if (dy > 0)
						dy = move_fwd(y2, dy, x, x2, eff(rows_q, MAX_ROWS), 1'b0, FACE_TOP);
					else if (dy < 0)
						dy = move_back(y, dy, x, x2, 1'b0, FACE_BOTTOM);
					exp_w = '0;
					exp_w.allowed_dx = OUT_W'(sat13(dx));
					exp_w.allowed_dy = OUT_W'(sat13(dy));
					move_q.push_back(exp_w);
					queries_seen++;
				end
			end
			if (m_tvalid && m_tready) begin
				got_w = m_tdata;
				results_checked++;
				if (move_q.size() == 0) begin
					$error("unexpected result word dx=%0d dy=%0d", got_w.allowed_dx,
						got_w.allowed_dy);
					mismatches++;
				end else begin
					exp_w = move_q.pop_front();
					if (got_w.allowed_dx !== exp_w.allowed_dx) begin
						$error("allowed_dx: expected %0d, got %0d", exp_w.allowed_dx,
							got_w.allowed_dx);
						mismatches++;
					end
					if (got_w.allowed_dy !== exp_w.allowed_dy) begin
						$error("allowed_dy: expected %0d, got %0d", exp_w.allowed_dy,
							got_w.allowed_dy);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall patterns, plus one long hold on request
	initial begin
		int mode, span;
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
				repeat (span) begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 7) != 0);
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_word(logic req, in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_cell(int row, int col, int faces);
		in_word_t w;
		w = 80'({$urandom(), $urandom(), $urandom()});
		w.pad        = '0;
		w.cell_row   = 8'(row);
		w.cell_col   = 8'(col);
		w.cell_faces = 4'(faces);
		send_word(REQ_WRITE, w);
	endtask

	task automatic send_query(int x, int y, int wd, int ht, int dx, int dy);
		in_word_t w;
		w = 80'({$urandom(), $urandom(), $urandom()});
		w.pad         = '0;
		w.rect_x      = 12'(x);
		w.rect_y      = 12'(y);
		w.rect_width  = 8'(wd);
		w.rect_height = 8'(ht);
		w.move_dx     = 8'(dx);
		w.move_dy     = 8'(dy);
		send_word(REQ_QUERY, w);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (move_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic clamp, logic [8:0] cols, logic [8:0] rows);
		cfg_reg_t idx;
		settle();
		idx = idx.first();
		repeat (3) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= (idx == CFG_CLAMP) ? {8'd0, clamp} : (idx == CFG_COLS) ? cols : rows;
			do @(posedge clk); while (!cfg_ready);
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic int pick_cell(int hot);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, hot);
	endfunction

	function automatic int pick_pos(int hot, int edge_px);
		int r, lo, p;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(0, hot * 8 + 16);
		if (r < 8) begin
			lo = (edge_px > 48) ? edge_px - 48 : 0;
			p  = lo + $urandom_range(0, 96);
			return (p > 4095) ? 4095 : p;
		end
		return $urandom_range(0, 4095);
	endfunction

	function automatic int pick_size();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
	endfunction

	function automatic int pick_move();
		return $urandom_range(0, 1) ? int'($urandom_range(0, 255)) - 128 :
			int'($urandom_range(0, 24)) - 12;
	endfunction

	// dense cell writes near the origin so that most queries meet solid faces
	task automatic random_items(int n, int hot);
		int px, py;
		px = eff(cols_q, MAX_COLUMNS) << CELL_SHIFT;
		py = eff(rows_q, MAX_ROWS) << CELL_SHIFT;
		repeat (n) begin
			if ($urandom_range(0, 9) < 3)
				send_cell(pick_cell(hot), pick_cell(hot), $urandom_range(0, 15));
			else
				send_query(pick_pos(hot, px), pick_pos(hot, py), pick_size(), pick_size(),
					pick_move(), pick_move());
		end
	endtask

	task automatic test_directed();
		send_cell(0, 0, 15);
		send_cell(255, 255, 15);
		send_cell(2, 5, FACE_LEFT);
		send_query(30, 16, 8, 8, 5, 0);        // right into a left face
		send_query(30, 16, 8, 8, 127, 0);      // long move skips the solid column
		send_cell(2, 1, FACE_RIGHT);
		send_query(17, 16, 8, 8, -5, 0);       // left into a right face
		send_cell(6, 3, FACE_TOP);
		send_query(24, 40, 4, 8, 0, 3);        // down onto a top face
		send_cell(1, 3, FACE_BOTTOM);
		send_query(24, 20, 4, 4, 0, -8);       // up into a bottom face
		send_query(3, 2, 6, 6, -128, -128);    // cut at the top and left edges
		send_query(9, 0, 4, 4, -3, 0);         // corner cell, all faces solid
		send_query(2030, 2040, 4, 4, 8, 0);    // last map cell
		send_query(4095, 4095, 255, 255, 127, 127);
		send_query(4095, 4095, 0, 0, -128, -128);
		send_query(0, 0, 255, 255, 0, 0);
		send_query(2040, 2040, 1, 1, 7, 7);    // right and bottom moves reach the last pixel, no clamp
	endtask

	task automatic test_default_map();
		random_items(140, 15);
	endtask

	task automatic test_small_map_unclamped();
		write_regs(1'b0, 9'd20, 9'd13);
		random_items(110, 24);
	endtask

	task automatic test_minimal_map();
		write_regs(1'b1, 9'd0, 9'd1);
		random_items(50, 4);
	endtask

	task automatic test_backpressure();
		write_regs(1'b0, 9'd511, 9'd256);
		rx_hold_req = 1'b1;
		random_items(80, 15);
	endtask

	task automatic test_steady_flow();
		write_regs(1'b1, 9'd256, 9'd256);
		sender_steady = 1'b1;
		random_items(100, 15);
		sender_steady = 1'b0;
	endtask

	initial begin
		foreach (face_map[r, c]) face_map[r][c] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_default_map();
		test_small_map_unclamped();
		test_minimal_map();
		test_backpressure();
		test_steady_flow();
		settle();
		$display("Run covered %0d cell writes and %0d motion queries under %0d map settings",
			writes_seen, queries_seen, settings_used + 1);
		$display("%0d result words checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== grid_motion_collision_filter_core.f =====
+incdir+design
design/gmcf_pkg.sv
design/gmcf_cell_store.sv
design/gmcf_axis_unit.sv
design/grid_motion_collision_filter_core.sv
dv/tb_top.sv
